FILE: rtl/core/eirc_pkg.sv
// ----------------------------------------------------------------------------
// eirc_pkg
// Shared types and constants of the energy integrator with rollover check.
// ----------------------------------------------------------------------------
package eirc_pkg;

	localparam int WALL_W   = 48;
	localparam int UPT_W    = 40;
	localparam int PWR_W    = 24;
	localparam int PSUM_W   = PWR_W + 1;
	localparam int TOL_W    = 16;
	localparam int STEP_E_W = 56;
	localparam int SUM_E_W  = 64;
	localparam int ROLL_W   = 16;
	localparam int CLS_W    = 3;
	localparam int HALF_W   = WALL_W / 2;
	localparam int PP_W     = PSUM_W + HALF_W;
	localparam int PROD_W   = PSUM_W + WALL_W;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [TOL_W-1:0] WALL_TOL_RST = 16'd2000;
	localparam logic [TOL_W-1:0] CNT_TOL_RST  = 16'd1000;

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_TOL = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CNT_TOL  = 1'd1;

	localparam logic [CLS_W-1:0] CLS_FIRST     = 3'd0;
	localparam logic [CLS_W-1:0] CLS_OK        = 3'd1;
	localparam logic [CLS_W-1:0] CLS_WALL_IMP  = 3'd2;
	localparam logic [CLS_W-1:0] CLS_ROLLOVER  = 3'd3;
	localparam logic [CLS_W-1:0] CLS_PWR_LOSS  = 3'd4;
	localparam logic [CLS_W-1:0] CLS_INCONSIST = 3'd5;

	typedef struct packed {
		logic [CLS_W-1:0]  cls;
		logic [WALL_W-1:0] step_time;
		logic [PSUM_W-1:0] power;
		logic              halve;
	} credit_t;

endpackage

FILE: rtl/core/eirc_front.sv
// ----------------------------------------------------------------------------
// eirc_front
// Takes samples, keeps the previous one, forms deltas and classifies the pair.
// ----------------------------------------------------------------------------
module eirc_front (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [eirc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [eirc_pkg::TOL_W-1:0]             cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [eirc_pkg::WALL_W-1:0]            wall_ms,
	input  logic [eirc_pkg::UPT_W-1:0]             uptime_cur_ms,
	input  logic [eirc_pkg::UPT_W-1:0]             uptime_tot_ms,
	input  logic [eirc_pkg::PWR_W-1:0]             power_mw,
	input  logic                                   q_full,
	output logic                                   q_push,
	output eirc_pkg::credit_t                      q_data
);

	logic [eirc_pkg::TOL_W-1:0]  wtol_q, ctol_q;
	logic [eirc_pkg::WALL_W-1:0] prev_wall_q;
	logic [eirc_pkg::UPT_W-1:0]  prev_cur_q, prev_tot_q;
	logic [eirc_pkg::PWR_W-1:0]  prev_pwr_q;
	logic                        have_prev_q;

	logic                               v_s1, first_s1;
	logic signed [eirc_pkg::WALL_W:0]   dwall_s1;
	logic signed [eirc_pkg::UPT_W:0]    dtot_s1, dcur_s1;
	logic [eirc_pkg::UPT_W-1:0]         cur_s1;
	logic [eirc_pkg::PWR_W-1:0]         pwr_s1;
	logic [eirc_pkg::PSUM_W-1:0]        psum_s1;

	logic                               acc, adv;
	logic signed [eirc_pkg::WALL_W+1:0] d_wt, tw;
	logic signed [eirc_pkg::UPT_W+1:0]  d_tc, tc;
	logic                               ok, imp, roll, ploss;
	logic signed [eirc_pkg::WALL_W:0]   credit;

	assign adv      = !v_s1 || !q_full;
	assign in_ready = adv;
	assign acc      = in_valid && in_ready;
	assign q_push   = v_s1 && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wtol_q <= eirc_pkg::WALL_TOL_RST;
			ctol_q <= eirc_pkg::CNT_TOL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				eirc_pkg::REG_WALL_TOL: wtol_q <= cfg_data;
				eirc_pkg::REG_CNT_TOL:  ctol_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_wall_q <= '0;
			prev_cur_q  <= '0;
			prev_tot_q  <= '0;
			prev_pwr_q  <= '0;
			have_prev_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			if (acc) begin
				prev_wall_q <= wall_ms;
				prev_cur_q  <= uptime_cur_ms;
				prev_tot_q  <= uptime_tot_ms;
				prev_pwr_q  <= power_mw;
				have_prev_q <= 1'b1;
			end
			if (adv)
				v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			first_s1 <= !have_prev_q;
			dwall_s1 <= $signed({1'b0, wall_ms} - {1'b0, prev_wall_q});
			dtot_s1  <= $signed({1'b0, uptime_tot_ms} - {1'b0, prev_tot_q});
			dcur_s1  <= $signed({1'b0, uptime_cur_ms} - {1'b0, prev_cur_q});
			cur_s1   <= uptime_cur_ms;
			pwr_s1   <= power_mw;
			psum_s1  <= {1'b0, prev_pwr_q} + {1'b0, power_mw};
		end
	end

	always_comb begin
		d_wt  = $signed({dwall_s1[eirc_pkg::WALL_W], dwall_s1})
		      - $signed({{9{dtot_s1[eirc_pkg::UPT_W]}}, dtot_s1});
		tw    = $signed({34'd0, wtol_q});
		d_tc  = $signed({dtot_s1[eirc_pkg::UPT_W], dtot_s1})
		      - $signed({dcur_s1[eirc_pkg::UPT_W], dcur_s1});
		tc    = $signed({26'd0, ctol_q});
		ok    = (d_wt < tw) && (d_wt > -tw);
		imp   = (d_tc < tc) && (d_tc > -tc);
		roll  = dwall_s1 > $signed({9'd0, cur_s1});
		ploss = dtot_s1 < $signed({1'b0, cur_s1});

		q_data.power = psum_s1;
		q_data.halve = 1'b1;
		credit       = '0;
		priority if (first_s1) begin
			q_data.cls = eirc_pkg::CLS_FIRST;
		end else if (ok) begin
			q_data.cls = eirc_pkg::CLS_OK;
			credit     = dwall_s1;
		end else if (imp) begin
			q_data.cls = eirc_pkg::CLS_WALL_IMP;
			credit     = dwall_s1;
		end else if (roll && ploss) begin
			q_data.cls   = eirc_pkg::CLS_PWR_LOSS;
			credit       = $signed({9'd0, cur_s1});
			q_data.power = {1'b0, pwr_s1};
			q_data.halve = 1'b0;
		end else if (roll) begin
			q_data.cls = eirc_pkg::CLS_ROLLOVER;
			credit     = $signed({{8{dtot_s1[eirc_pkg::UPT_W]}}, dtot_s1});
		end else begin
			q_data.cls = eirc_pkg::CLS_INCONSIST;
		end
		q_data.step_time = credit[eirc_pkg::WALL_W] ? '0 : credit[eirc_pkg::WALL_W-1:0];
	end

endmodule

FILE: rtl/core/eirc_queue.sv
// ----------------------------------------------------------------------------
// eirc_queue
// Short FIFO of classified credits between front and back.
// ----------------------------------------------------------------------------
module eirc_queue #(
	parameter int DEPTH = eirc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  eirc_pkg::credit_t push_data,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output eirc_pkg::credit_t pop_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	eirc_pkg::credit_t entry_q [DEPTH];
	logic [PTR_W-1:0]  wr_q, rd_q;
	logic [CNT_W-1:0]  cnt_q;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign pop_data  = entry_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_q] <= push_data;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue write while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("queue read while empty");

endmodule

FILE: rtl/core/eirc_back.sv
// ----------------------------------------------------------------------------
// eirc_back
// Energy multiply in two stages, then saturating totals and result register.
// ----------------------------------------------------------------------------
module eirc_back (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  q_valid,
	input  eirc_pkg::credit_t                     q_data,
	output logic                                  q_pop,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [eirc_pkg::CLS_W-1:0]            sample_class,
	output logic [eirc_pkg::WALL_W-1:0]           step_time_ms,
	output logic [eirc_pkg::STEP_E_W-1:0]         step_energy_uj,
	output logic [eirc_pkg::WALL_W-1:0]           sum_time_ms,
	output logic [eirc_pkg::SUM_E_W-1:0]          sum_energy_uj,
	output logic [eirc_pkg::ROLL_W-1:0]           rollovers_seen,
	output logic                                  bad_seen
);

	localparam int HW = eirc_pkg::HALF_W;

	logic                           v_s1, v_s2, out_v_q;
	logic                           en1, en2, en_out;
	logic [eirc_pkg::CLS_W-1:0]     cls_s1, cls_s2, cls_q;
	logic [eirc_pkg::WALL_W-1:0]    st_s1, st_s2, st_q;
	logic                           halve_s1;
	logic [eirc_pkg::PP_W-1:0]      lo_s1, hi_s1;
	logic [eirc_pkg::STEP_E_W-1:0]  se_s2, se_q;

	logic [eirc_pkg::PROD_W-1:0]    prod, shifted;
	logic [eirc_pkg::STEP_E_W-1:0]  se_sat;

	logic [eirc_pkg::WALL_W-1:0]    tot_time_q;
	logic [eirc_pkg::SUM_E_W-1:0]   tot_energy_q;
	logic [eirc_pkg::ROLL_W-1:0]    roll_q;
	logic                           bad_q;
	logic [eirc_pkg::WALL_W:0]      t_add;
	logic [eirc_pkg::SUM_E_W:0]     e_add;
	logic                           is_roll;

	assign en_out = !out_v_q || out_ready;
	assign en2    = !v_s2 || en_out;
	assign en1    = !v_s1 || en2;
	assign q_pop  = q_valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1)
				v_s1 <= q_valid;
			if (en2)
				v_s2 <= v_s1;
			if (en_out)
				out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cls_s1   <= q_data.cls;
			st_s1    <= q_data.step_time;
			halve_s1 <= q_data.halve;
			lo_s1    <= q_data.power * q_data.step_time[HW-1:0];
			hi_s1    <= q_data.power * q_data.step_time[eirc_pkg::WALL_W-1:HW];
		end
	end

	always_comb begin
		prod    = eirc_pkg::PROD_W'(lo_s1) + (eirc_pkg::PROD_W'(hi_s1) << HW);
		shifted = halve_s1 ? (prod >> 1) : prod;
		se_sat  = (|shifted[eirc_pkg::PROD_W-1:eirc_pkg::STEP_E_W]) ? '1
		        : shifted[eirc_pkg::STEP_E_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en2 && v_s1) begin
			cls_s2 <= cls_s1;
			st_s2  <= st_s1;
			se_s2  <= se_sat;
		end
	end

	always_comb begin
		t_add   = {1'b0, tot_time_q} + {1'b0, st_s2};
		e_add   = {1'b0, tot_energy_q} + {9'd0, se_s2};
		is_roll = (cls_s2 == eirc_pkg::CLS_ROLLOVER) || (cls_s2 == eirc_pkg::CLS_PWR_LOSS);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tot_time_q   <= '0;
			tot_energy_q <= '0;
			roll_q       <= '0;
			bad_q        <= 1'b0;
		end else if (en_out && v_s2) begin
			tot_time_q   <= t_add[eirc_pkg::WALL_W] ? '1 : t_add[eirc_pkg::WALL_W-1:0];
			tot_energy_q <= e_add[eirc_pkg::SUM_E_W] ? '1 : e_add[eirc_pkg::SUM_E_W-1:0];
			if (is_roll && !(&roll_q))
				roll_q <= roll_q + 1'b1;
			if (cls_s2 == eirc_pkg::CLS_INCONSIST)
				bad_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			cls_q <= cls_s2;
			st_q  <= st_s2;
			se_q  <= se_s2;
		end
	end

	assign out_valid      = out_v_q;
	assign sample_class   = cls_q;
	assign step_time_ms   = st_q;
	assign step_energy_uj = se_q;
	assign sum_time_ms    = tot_time_q;
	assign sum_energy_uj  = tot_energy_q;
	assign rollovers_seen = roll_q;
	assign bad_seen       = bad_q;

	a_no_credit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && (cls_q == eirc_pkg::CLS_FIRST || cls_q == eirc_pkg::CLS_INCONSIST))
		|-> (st_q == '0 && se_q == '0))
		else $error("credit given for uncredited class");

	a_bad_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		bad_q |=> bad_q)
		else $error("bad flag cleared");

	a_bad_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && cls_q == eirc_pkg::CLS_INCONSIST) |-> bad_q)
		else $error("inconsistent beat without bad flag");

endmodule

FILE: rtl/core/energy_integrator_with_rollover_check_core.sv
// Throughput: one sample per cycle while the output is not stalled; the credit
// queue decouples the classifier from the multiply and accumulate stages.
// Energy multiply is split into two 25x24 partial products over two stages.
// Reset (arst_n low, asynchronous): no previous sample, totals, rollover count
// and bad flag cleared, tolerances back to 2000 ms and 1000 ms.
// ----------------------------------------------------------------------------
// energy_integrator_with_rollover_check_core
// Classifies power-supply samples against the previous one, integrates credited
// time and trapezoidal energy, rectangular on power loss, in saturating totals.
// ----------------------------------------------------------------------------
module energy_integrator_with_rollover_check_core #(
	parameter int QUEUE_DEPTH = eirc_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [eirc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [eirc_pkg::TOL_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [eirc_pkg::WALL_W-1:0]           wall_ms,
	input  logic [eirc_pkg::UPT_W-1:0]            uptime_cur_ms,
	input  logic [eirc_pkg::UPT_W-1:0]            uptime_tot_ms,
	input  logic [eirc_pkg::PWR_W-1:0]            power_mw,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [eirc_pkg::CLS_W-1:0]            sample_class,
	output logic [eirc_pkg::WALL_W-1:0]           step_time_ms,
	output logic [eirc_pkg::STEP_E_W-1:0]         step_energy_uj,
	output logic [eirc_pkg::WALL_W-1:0]           sum_time_ms,
	output logic [eirc_pkg::SUM_E_W-1:0]          sum_energy_uj,
	output logic [eirc_pkg::ROLL_W-1:0]           rollovers_seen,
	output logic                                  bad_seen
);

	logic              q_full, q_push, q_pop, q_valid;
	eirc_pkg::credit_t q_wdata, q_rdata;

	eirc_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.wall_ms       (wall_ms),
		.uptime_cur_ms (uptime_cur_ms),
		.uptime_tot_ms (uptime_tot_ms),
		.power_mw      (power_mw),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_data        (q_wdata)
	);

	eirc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_rdata)
	);

	eirc_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.q_valid        (q_valid),
		.q_data         (q_rdata),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.sample_class   (sample_class),
		.step_time_ms   (step_time_ms),
		.step_energy_uj (step_energy_uj),
		.sum_time_ms    (sum_time_ms),
		.sum_energy_uj  (sum_energy_uj),
		.rollovers_seen (rollovers_seen),
		.bad_seen       (bad_seen)
	);

endmodule

FILE: dv/energy_integrator_with_rollover_check_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// energy_integrator_with_rollover_check_core_test
// Self-checking bench for the energy integrator. A driver feeds sample beats
// from a backlog, an in-bench integrator predicts each class and tally, and a
// monitor compares every result beat field by field. Tolerances are changed
// between phases while the core is idle; both sides idle and stall at random.
// ----------------------------------------------------------------------------
module energy_integrator_with_rollover_check_core_test;
	import eirc_pkg::*;

	typedef struct packed {
		logic [WALL_W-1:0] wall;
		logic [UPT_W-1:0]  cur;
		logic [UPT_W-1:0]  tot;
		logic [PWR_W-1:0]  pwr;
	} sample_t;

	typedef struct packed {
		logic [CLS_W-1:0]    cls;
		logic [WALL_W-1:0]   step_t;
		logic [STEP_E_W-1:0] step_e;
		logic [WALL_W-1:0]   sum_t;
		logic [SUM_E_W-1:0]  sum_e;
		logic [ROLL_W-1:0]   rolls;
		logic                bad;
	} tally_t;

	localparam logic [WALL_W-1:0]   WALL_MAX   = '1;
	localparam logic [UPT_W-1:0]    UPT_MAX    = '1;
	localparam logic [PWR_W-1:0]    PWR_MAX    = '1;
	localparam logic [STEP_E_W-1:0] STEP_E_MAX = '1;
	localparam logic [ROLL_W-1:0]   ROLL_MAX   = '1;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_ITEMS   = 340;
	localparam int DRAIN_CYCLES  = 10;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_WALL_TOL;
	logic [TOL_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [WALL_W-1:0]    wall_ms = '0;
	logic [UPT_W-1:0]     uptime_cur_ms = '0;
	logic [UPT_W-1:0]     uptime_tot_ms = '0;
	logic [PWR_W-1:0]     power_mw = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [CLS_W-1:0]     sample_class;
	logic [WALL_W-1:0]    step_time_ms;
	logic [STEP_E_W-1:0]  step_energy_uj;
	logic [WALL_W-1:0]    sum_time_ms;
	logic [SUM_E_W-1:0]   sum_energy_uj;
	logic [ROLL_W-1:0]    rollovers_seen;
	logic                 bad_seen;

	energy_integrator_with_rollover_check_core dut (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// integrator state mirrored in the bench
	logic [TOL_W-1:0]   tol_wall = WALL_TOL_RST;
	logic [TOL_W-1:0]   tol_cnt = CNT_TOL_RST;
	logic [WALL_W-1:0]  last_wall = '0;
	logic [UPT_W-1:0]   last_cur = '0;
	logic [UPT_W-1:0]   last_tot = '0;
	logic [PWR_W-1:0]   last_pwr = '0;
	logic               seen_first = 1'b0;
	logic [WALL_W-1:0]  acc_time = '0;
	logic [SUM_E_W-1:0] acc_energy = '0;
	logic [ROLL_W-1:0]  roll_cnt = '0;
	logic               bad_latch = 1'b0;

	sample_t sample_backlog[$];
	tally_t  tally_queue[$];
	sample_t gen = '0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      mismatches = 0;

	function automatic tally_t integrate_sample(sample_t s);
		tally_t r;
		longint d_wall, d_tot, d_cur, up, credit, gap;
		logic give, trap;
		logic [127:0] pw, tw, prod;
		logic [WALL_W:0] tsum;
		logic [SUM_E_W:0] esum;
		r = '0;
		r.cls = CLS_FIRST;
		if (seen_first) begin
			d_wall = $signed({16'd0, s.wall}) - $signed({16'd0, last_wall});
			d_tot = $signed({24'd0, s.tot}) - $signed({24'd0, last_tot});
			d_cur = $signed({24'd0, s.cur}) - $signed({24'd0, last_cur});
			up = $signed({24'd0, s.cur});
			give = 1'b1;
			trap = 1'b1;
			credit = 0;
			gap = d_wall - d_tot;
			if (gap < 0)
				gap = -gap;
			if (gap < longint'(tol_wall)) begin
				r.cls = CLS_OK;
				credit = d_wall;
			end else begin
				gap = d_tot - d_cur;
				if (gap < 0)
					gap = -gap;
				if (gap < longint'(tol_cnt)) begin
					r.cls = CLS_WALL_IMP;
					credit = d_wall;
				end else if (d_wall > up) begin
					if (roll_cnt != ROLL_MAX)
						roll_cnt = roll_cnt + 1'b1;
					if (d_tot < up) begin
						r.cls = CLS_PWR_LOSS;
						credit = up;
						trap = 1'b0;
					end else begin
						r.cls = CLS_ROLLOVER;
						credit = d_tot;
					end
				end else begin
					r.cls = CLS_INCONSIST;
					bad_latch = 1'b1;
					give = 1'b0;
				end
			end
			if (give) begin
				r.step_t = (credit < 0) ? '0 : credit[WALL_W-1:0];
				tw = 128'(r.step_t);
				if (trap) begin
					pw = 128'(last_pwr);
					pw = pw + 128'(s.pwr);
					prod = (pw * tw) >> 1;
				end else begin
					pw = 128'(s.pwr);
					prod = pw * tw;
				end
				r.step_e = (prod > 128'(STEP_E_MAX)) ? STEP_E_MAX : prod[STEP_E_W-1:0];
				tsum = {1'b0, acc_time} + {1'b0, r.step_t};
				acc_time = tsum[WALL_W] ? WALL_MAX : tsum[WALL_W-1:0];
				esum = {1'b0, acc_energy} + {9'd0, r.step_e};
				acc_energy = esum[SUM_E_W] ? '1 : esum[SUM_E_W-1:0];
			end
		end
		last_wall = s.wall;
		last_cur = s.cur;
		last_tot = s.tot;
		last_pwr = s.pwr;
		seen_first = 1'b1;
		r.sum_t = acc_time;
		r.sum_e = acc_energy;
		r.rolls = roll_cnt;
		r.bad = bad_latch;
		return r;
	endfunction

	function automatic sample_t make_sample();
		int unsigned pick, dt, up;
		logic [WALL_W-1:0] jump;
		pick = $urandom_range(99);
		dt = $urandom_range(60000);
		case ($urandom_range(3))
			0: gen.pwr = PWR_W'($urandom_range(300000));
			1: gen.pwr = PWR_W'($urandom);
			2: gen.pwr = PWR_MAX;
			default: ;
		endcase
		if (pick < 32) begin
			gen.cur += UPT_W'(dt);
			gen.tot += UPT_W'(dt);
			gen.wall += WALL_W'(dt + $urandom_range(2500));
		end else if (pick < 42) begin
			// wall clock adjusted, counters agree
			gen.cur += UPT_W'(dt);
			gen.tot += UPT_W'(dt + $urandom_range(1500));
			if ($urandom_range(1))
				gen.wall += WALL_W'($urandom_range(30000000) + 3000);
			else
				gen.wall -= WALL_W'($urandom_range(30000000));
		end else if (pick < 52) begin
			// current uptime wrapped
			dt = $urandom_range(10000000, 1000);
			gen.cur = UPT_W'($urandom_range(dt - 1));
			gen.tot += UPT_W'(dt);
			gen.wall += WALL_W'(dt + 3000 + $urandom_range(1000000));
		end else if (pick < 60) begin
			// power lost for a while
			up = $urandom_range(5000000, 1000);
			gen.cur = UPT_W'(up);
			gen.tot += UPT_W'($urandom_range(up - 1));
			gen.wall += WALL_W'(up + 3000 + $urandom_range(10000000));
		end else if (pick < 67) begin
			gen.wall += WALL_W'($urandom_range(100));
			gen.tot += UPT_W'($urandom_range(1000000, 100000));
			gen.cur += UPT_W'($urandom_range(3000000, 2000000));
		end else if (pick < 73) begin
			gen.cur -= UPT_W'(dt);
			gen.tot -= UPT_W'(dt);
			gen.wall -= WALL_W'(dt);
		end else if (pick < 89) begin
			// long gaps at high power drive the totals toward saturation
			gen.pwr = PWR_W'($urandom_range(16777215, 14000000));
			jump = WALL_W'({$urandom, $urandom});
			if ($urandom_range(1)) begin
				gen.wall += {8'd0, jump[UPT_W-1:0]};
				gen.tot += jump[UPT_W-1:0];
				gen.cur += jump[UPT_W-1:0];
			end else begin
				gen.wall += jump;
			end
		end else begin
			case ($urandom_range(3))
				0: gen = '0;
				1: gen = '1;
				default: gen = sample_t'($bits(sample_t)'({$urandom, $urandom, $urandom,
					$urandom, $urandom}));
			endcase
		end
		return gen;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic queue_sample(logic [WALL_W-1:0] w, logic [UPT_W-1:0] c,
			logic [UPT_W-1:0] t, logic [PWR_W-1:0] p);
		sample_backlog.push_back({w, c, t, p});
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [TOL_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_WALL_TOL)
			tol_wall = val;
		else
			tol_cnt = val;
	endtask

	task automatic settle();
		@(negedge clk);
		while (sample_backlog.size() != 0 || in_valid || tally_queue.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// sample beats
	always @(posedge clk) begin
		sample_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				tally_queue.push_back(integrate_sample({wall_ms, uptime_cur_ms,
					uptime_tot_ms, power_mw}));
			if (!in_valid || in_ready) begin
				if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = sample_backlog.pop_front();
					{wall_ms, uptime_cur_ms, uptime_tot_ms, power_mw} <= nxt;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result beats
	always @(posedge clk) begin
		tally_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (tally_queue.size() == 0) begin
					report_mismatch("unexpected result", {61'd0, sample_class}, '0);
				end else begin
					want = tally_queue.pop_front();
					if (sample_class !== want.cls)
						report_mismatch("sample_class", 64'(sample_class),
							64'(want.cls));
					if (step_time_ms !== want.step_t)
						report_mismatch("step_time_ms", 64'(step_time_ms),
							64'(want.step_t));
					if (step_energy_uj !== want.step_e)
						report_mismatch("step_energy_uj", 64'(step_energy_uj),
							64'(want.step_e));
					if (sum_time_ms !== want.sum_t)
						report_mismatch("sum_time_ms", 64'(sum_time_ms),
							64'(want.sum_t));
					if (sum_energy_uj !== want.sum_e)
						report_mismatch("sum_energy_uj", sum_energy_uj, want.sum_e);
					if (rollovers_seen !== want.rolls)
						report_mismatch("rollovers_seen", 64'(rollovers_seen),
							64'(want.rolls));
					if (bad_seen !== want.bad)
						report_mismatch("bad_seen", 64'(bad_seen), 64'(want.bad));
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		logic [TOL_W-1:0] tw, tc;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, reset tolerances 2000 / 1000
		queue_sample(48'd0, 40'd0, 40'd0, 24'd0);
		queue_sample(48'd1000, 40'd1000, 40'd1000, 24'd100000);
		queue_sample(48'd3999, 40'd2000, 40'd2000, 24'd100000);
		queue_sample(48'd6999, 40'd3000, 40'd3000, 24'd150000);
		queue_sample(48'd506999, 40'd3001, 40'd4000, 24'd200000);
		queue_sample(48'd1506999, 40'd3001, 40'd5000, 24'd300000);
		queue_sample(48'd2406999, 40'd10, 40'd505000, PWR_MAX);
		queue_sample(48'd2407009, 40'd500010, 40'd605000, 24'd1234);
		queue_sample(48'd2404009, 40'd497010, 40'd602000, 24'd5000);
		queue_sample(48'd2000000, 40'd498010, 40'd603000, 24'd6000);
		queue_sample(WALL_MAX, UPT_MAX, UPT_MAX, PWR_MAX);
		queue_sample(48'd0, 40'd0, 40'd0, 24'd0);
		queue_sample({8'd0, UPT_MAX}, 40'd0, UPT_MAX, PWR_MAX);
		queue_sample(WALL_MAX, 40'd0, UPT_MAX, PWR_MAX);
		queue_sample(48'd0, 40'd0, UPT_MAX, 24'd0);
		queue_sample(WALL_MAX, 40'd0, UPT_MAX, 24'd0);
		queue_sample(WALL_MAX, 40'd0, UPT_MAX, 24'd5);
		gen = {WALL_MAX, 40'd0, UPT_MAX, 24'd5};
		settle();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			case (ph)
				0: begin tw = 16'd2000; tc = 16'd1000; end
				1: begin tw = 16'd0; tc = 16'd0; end
				2: begin tw = 16'hFFFF; tc = 16'hFFFF; end
				3: begin tw = 16'hFFFF; tc = 16'd0; end
				default: begin
					tw = TOL_W'($urandom_range(65535));
					tc = TOL_W'($urandom_range(65535));
				end
			endcase
			set_reg(REG_WALL_TOL, tw);
			set_reg(REG_CNT_TOL, tc);
			@(negedge clk);
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 77; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 77; end
				default: begin send_idle_pct = 12; recv_stall_pct = 12; end
			endcase
			repeat (PHASE_ITEMS) sample_backlog.push_back(make_sample());
			settle();
		end

		if (tally_queue.size() != 0)
			report_mismatch("results missing", 64'(tally_queue.size()), '0);
		if (mismatches == 0)
			$display("energy_integrator_with_rollover_check_core_test: done, clean");
		else
			$display("energy_integrator_with_rollover_check_core_test: done, errors");
		$finish;
	end

	initial begin
		#3000000;
		$display("energy_integrator_with_rollover_check_core_test: done, errors");
		$finish;
	end

endmodule
